>>> design/direct_dft_engine_defines.svh
// Assertion macros shared by the engine's modules.
// Each macro samples on the rising edge of clock and is quiet while reset is high.
`ifndef DIRECT_DFT_ENGINE_DEFINES_SVH
`define DIRECT_DFT_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define DDE_ASSERT_IMPLY(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("direct_dft_engine: same-cycle check failed");

// Next-cycle implication.
`define DDE_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("direct_dft_engine: next-cycle check failed");

`endif

>>> design/dde_pkg.sv
package dde_pkg;

   // Transform size. It must be a power of two, because the output scaling is a shift.
   localparam int POINTS   = 64;
   localparam int IDX_W    = $clog2(POINTS);
   localparam int SAMPLE_W = 16;
   localparam int BIN_W    = 6;
   localparam int TW_W     = 2 * SAMPLE_W;
   // A product pair sums to at most 2^31; POINTS of those sums are accumulated.
   localparam int ACC_W    = 2 * SAMPLE_W + 1 + IDX_W;
   // The 1/POINTS scaling and the Q1.15 realignment together are one right shift.
   localparam int SHIFT    = SAMPLE_W - 1 + IDX_W;
   localparam int ROUND_HALF = 1 << (SHIFT - 1);
   localparam int Q15_MAX  = 32767;
   localparam int Q15_MIN  = -32768;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

   localparam logic [63:0] Q30_ONE  = 64'd1073741824;
   localparam logic [63:0] Q30_PI_4 = 64'd843314857;

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_CALC  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic             first;
      logic             last_term;
      logic [IDX_W-1:0] k;
   } mac_tag_type;

   typedef logic [POINTS-1:0][TW_W-1:0] twiddle_table_type;

   function automatic logic [63:0] qmul30_f(input logic [63:0] a, input logic [63:0] b);
      return (a * b + 64'd536870912) >> 30;
   endfunction

   function automatic logic [15:0] q30_to_q15_f(input logic [63:0] v);
      logic [63:0] r;
      r = (v + 64'd16384) >> 15;
      return (r > 64'd32767) ? 16'd32767 : r[15:0];
   endfunction

   // Octant-folded Taylor series, worked out at elaboration. Entry is {cos, sin}.
   function automatic logic [TW_W-1:0] twiddle_f(input int unsigned m);
      logic [63:0] q, rem, x, x2, s, c;
      logic [2:0]  oct;
      logic [15:0] sa, ca, cs, sn;
      q   = 64'(m) * 64'd8;
      oct = 3'(q / POINTS);
      rem = q % POINTS;
      if (oct[0]) rem = 64'(POINTS) - rem;
      x  = (Q30_PI_4 * rem + 64'(POINTS / 2)) / POINTS;
      x2 = qmul30_f(x, x);
      s  = Q30_ONE;
      s  = Q30_ONE - qmul30_f(x2, s) / 64'd110;
      s  = Q30_ONE - qmul30_f(x2, s) / 64'd72;
      s  = Q30_ONE - qmul30_f(x2, s) / 64'd42;
      s  = Q30_ONE - qmul30_f(x2, s) / 64'd20;
      s  = Q30_ONE - qmul30_f(x2, s) / 64'd6;
      s  = qmul30_f(x, s);
      c  = Q30_ONE;
      c  = Q30_ONE - qmul30_f(x2, c) / 64'd132;
      c  = Q30_ONE - qmul30_f(x2, c) / 64'd90;
      c  = Q30_ONE - qmul30_f(x2, c) / 64'd56;
      c  = Q30_ONE - qmul30_f(x2, c) / 64'd30;
      c  = Q30_ONE - qmul30_f(x2, c) / 64'd12;
      c  = Q30_ONE - qmul30_f(x2, c) / 64'd2;
      sa = q30_to_q15_f(s);
      ca = q30_to_q15_f(c);
      unique case (oct)
         3'd0: begin sn = sa;          cs = ca;          end
         3'd1: begin sn = ca;          cs = sa;          end
         3'd2: begin sn = ca;          cs = 16'd0 - sa;  end
         3'd3: begin sn = sa;          cs = 16'd0 - ca;  end
         3'd4: begin sn = 16'd0 - sa;  cs = 16'd0 - ca;  end
         3'd5: begin sn = 16'd0 - ca;  cs = 16'd0 - sa;  end
         3'd6: begin sn = 16'd0 - ca;  cs = sa;          end
         default: begin sn = 16'd0 - sa; cs = ca;        end
      endcase
      return {cs, sn};
   endfunction

   function automatic twiddle_table_type build_twiddle_rom_f();
      twiddle_table_type t;
      for (int i = 0; i < POINTS; i++) begin
         t[i] = twiddle_f(i);
      end
      return t;
   endfunction

   localparam twiddle_table_type TWIDDLE_ROM = build_twiddle_rom_f();

   // Scale by 1/POINTS into Q1.15, round half up, saturate.
   function automatic logic signed [SAMPLE_W-1:0] round_sat_f(
      input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0]       biased;
      logic signed [ACC_W-SHIFT-1:0] q;
      biased = acc + ACC_W'(ROUND_HALF);
      q      = (ACC_W-SHIFT)'(biased >>> SHIFT);
      if (q > Q15_MAX) return SAMPLE_W'(Q15_MAX);
      if (q < Q15_MIN) return SAMPLE_W'(Q15_MIN);
      return SAMPLE_W'(q);
   endfunction

endpackage

>>> design/dde_req_if.sv
interface dde_req_if;
   import dde_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_re;
   logic signed [SAMPLE_W-1:0] sample_im;

   modport source (output valid, output sample_re, output sample_im, input ready);
   modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

>>> design/dde_rsp_if.sv
interface dde_rsp_if;
   import dde_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] bin_re;
   logic signed [SAMPLE_W-1:0] bin_im;
   logic [BIN_W-1:0]           bin_index;
   logic                       last_bin;

   modport source (output valid, output bin_re, output bin_im, output bin_index,
                   output last_bin, input ready);
   modport sink   (input valid, input bin_re, input bin_im, input bin_index,
                   input last_bin, output ready);
endinterface

>>> design/direct_dft_engine.sv
// Load: one sample beat per cycle while loading; a frame is POINTS beats.
// Compute: one complex MAC per cycle against the sample store unless the pipeline is
// frozen by a full output slot; each bin accumulates POINTS terms.
// Bins start after the last sample beat; a new frame loads once the last bin is in the output register.
// Synchronous active-high reset clears control and valid flags; the store is not cleared.
`include "direct_dft_engine_defines.svh"

module direct_dft_engine (
   input  logic     clock,
   input  logic     reset,
   dde_req_if.sink   req_bus,
   dde_rsp_if.source rsp_bus
);
   import dde_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] load_cnt_ff, load_cnt_in;
   logic [IDX_W-1:0] n_ff, n_in, k_ff, k_in, m_ff, m_in;
   logic [IDX_W:0]   m_sum;

   logic [TW_W-1:0]  store_mem [POINTS];

   logic req_fire, adv, slot_free, fin_take, issue;

   logic                       s1_valid_ff, s2_valid_ff, fin_valid_ff, rsp_valid_ff;
   mac_tag_type                s1_tag_ff, s2_tag_ff;
   logic [TW_W-1:0]            rd_data_ff, tw_ff;
   logic signed [SAMPLE_W-1:0] s1_xr, s1_xi, s1_c, s1_s;
   logic signed [TW_W-1:0]     prod_rc_ff, prod_is_ff, prod_ic_ff, prod_rs_ff;
   logic signed [ACC_W-1:0]    acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic signed [ACC_W-1:0]    fin_re_ff, fin_im_ff;
   logic [IDX_W-1:0]           fin_k_ff;
   logic signed [SAMPLE_W-1:0] rsp_re_ff, rsp_im_ff;
   logic [BIN_W-1:0]           rsp_index_ff;
   logic                       rsp_last_ff;

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   // Freeze the MAC pipeline while a finished bin waits for the output slot.
   assign adv       = !fin_valid_ff || slot_free;
   assign fin_take  = fin_valid_ff && slot_free;
   assign issue     = (state_ff == ST_CALC) && adv;

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      m_in        = m_ff;
      m_sum       = {1'b0, m_ff} + {1'b0, k_ff};
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (load_cnt_ff == LAST_IDX) begin
                  load_cnt_in = '0;
                  n_in        = '0;
                  k_in        = '0;
                  m_in        = '0;
                  state_in    = ST_CALC;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_CALC: begin
            if (adv) begin
               if (n_ff == LAST_IDX) begin
                  n_in = '0;
                  m_in = '0;
                  k_in = k_ff + 1'b1;
                  if (k_ff == LAST_IDX) state_in = ST_DRAIN;
               end else begin
                  n_in = n_ff + 1'b1;
                  // advance the twiddle phase by k, mod POINTS
                  if (m_sum >= (IDX_W+1)'(POINTS)) begin
                     m_in = IDX_W'(m_sum - (IDX_W+1)'(POINTS));
                  end else begin
                     m_in = m_sum[IDX_W-1:0];
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (fin_take && fin_k_ff == LAST_IDX) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         n_ff        <= '0;
         k_ff        <= '0;
         m_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         n_ff        <= n_in;
         k_ff        <= k_in;
         m_ff        <= m_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) store_mem[load_cnt_ff] <= {req_bus.sample_im, req_bus.sample_re};
      if (issue) rd_data_ff <= store_mem[n_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            fin_valid_ff <= s2_valid_ff && s2_tag_ff.last_term;
         end
         if (fin_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign s1_xr = rd_data_ff[SAMPLE_W-1:0];
   assign s1_xi = rd_data_ff[TW_W-1:SAMPLE_W];
   assign s1_c  = tw_ff[TW_W-1:SAMPLE_W];
   assign s1_s  = tw_ff[SAMPLE_W-1:0];

   always_comb begin
      acc_re_in = (s2_tag_ff.first ? ACC_W'(0) : acc_re_ff)
                + ACC_W'(prod_rc_ff) + ACC_W'(prod_is_ff);
      acc_im_in = (s2_tag_ff.first ? ACC_W'(0) : acc_im_ff)
                + ACC_W'(prod_ic_ff) - ACC_W'(prod_rs_ff);
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         tw_ff     <= TWIDDLE_ROM[m_ff];
         s1_tag_ff <= '{first: (n_ff == '0), last_term: (n_ff == LAST_IDX), k: k_ff};
      end
      if (adv) begin
         prod_rc_ff <= s1_xr * s1_c;
         prod_is_ff <= s1_xi * s1_s;
         prod_ic_ff <= s1_xi * s1_c;
         prod_rs_ff <= s1_xr * s1_s;
         s2_tag_ff  <= s1_tag_ff;
         if (s2_valid_ff) begin
            acc_re_ff <= acc_re_in;
            acc_im_ff <= acc_im_in;
         end
         fin_re_ff <= acc_re_in;
         fin_im_ff <= acc_im_in;
         fin_k_ff  <= s2_tag_ff.k;
      end
      if (fin_take) begin
         rsp_re_ff    <= round_sat_f(fin_re_ff);
         rsp_im_ff    <= round_sat_f(fin_im_ff);
         rsp_index_ff <= BIN_W'(fin_k_ff);
         rsp_last_ff  <= (fin_k_ff == LAST_IDX);
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.bin_re    = rsp_re_ff;
   assign rsp_bus.bin_im    = rsp_im_ff;
   assign rsp_bus.bin_index = rsp_index_ff;
   assign rsp_bus.last_bin  = rsp_last_ff;

   `DDE_ASSERT_IMPLY(a_load_pipe_empty, req_bus.ready, !s1_valid_ff && !s2_valid_ff && !fin_valid_ff)
   `DDE_ASSERT_NEXT(a_frame_end_reload, fin_take && fin_k_ff == LAST_IDX, state_ff == ST_LOAD)
   `DDE_ASSERT_IMPLY(a_twiddle_phase, state_ff == ST_CALC, ((12'(n_ff) * 12'(k_ff)) % 12'(POINTS)) == 12'(m_ff))

endmodule
